// ===== design/sap_pkg.sv =====
// ----------------------------------------------------------------------------
// Slot allocator package
// Shared word types, command, status and slot state codes.
// ----------------------------------------------------------------------------
package sap_pkg;

    localparam int SLOTS_DEF = 64;
    localparam int ID_W      = 16;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_COMMIT  = 2'd2;
    localparam logic [1:0] CMD_REBUILD = 2'd3;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_NOFREE = 2'd1;
    localparam logic [1:0] STAT_REJECT = 2'd2;

    localparam logic [1:0] SS_FREE  = 2'd0;
    localparam logic [1:0] SS_ALLOC = 2'd1;
    localparam logic [1:0] SS_PEND  = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [5:0] slot_index;
    } t_in_word;

    typedef struct packed {
        logic [1:0]      status;
        logic [5:0]      granted_slot;
        logic [ID_W-1:0] object_id;
        logic [6:0]      released_count;
        logic [6:0]      active_count;
    } t_out_word;

endpackage

// ===== design/slot_allocator_deferred_release.sv =====
// ----------------------------------------------------------------------------
// Slot allocator with deferred release
// Fixed slot pool on a linked free list, with a queue of pending releases.
// ----------------------------------------------------------------------------
// Each input word carries a command and a slot index; each one gives exactly
// one result word. Both channels use valid and stall. The block takes one
// word at a time and stalls its input until that word's result is handed to
// the output register, so the input may be taken again while a result waits.
// A small sequencer drives three simple dual port RAMs (links, slot states and
// the release queue), one access pair per cycle with registered reads.
// Steps per word: allocate and release pass a work state, then the result
// (an allocate that finds the pool empty goes straight to the result);
// commit reads and relinks each queued release in turn; rebuild walks all
// SLOTS entries, reading back the state of each slot below the start slot S.
// After reset the block walks all SLOTS entries to build the free list and
// stalls its input until the walk is done. When the receiver stalls, the
// result holds in the output register and the next word finishes and then
// waits for the register to free up.
// ----------------------------------------------------------------------------
module slot_allocator_deferred_release #(
    parameter int SLOTS = sap_pkg::SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  sap_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sap_pkg::t_out_word o_out_word
);
    import sap_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] NONE = CW'(SLOTS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ALLOC  = 3'd1;
    localparam logic [2:0] S_REL    = 3'd2;
    localparam logic [2:0] S_CMT_RD = 3'd3;
    localparam logic [2:0] S_CMT_WR = 3'd4;
    localparam logic [2:0] S_RB_RD  = 3'd5;
    localparam logic [2:0] S_RB_WR  = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]      r_state, n_state;
    logic [CW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_qc, n_qc;
    logic [CW-1:0]   r_live, n_live;
    logic [ID_W-1:0] r_next_id, n_next_id;
    logic [CW-1:0]   r_i, n_i;
    logic [CW-1:0]   r_acc, n_acc;
    logic            r_init, n_init;
    logic [5:0]      r_idx, n_idx;
    logic            r_idx_ok, n_idx_ok;
    logic            r_out_valid, n_out_valid;
    t_out_word       r_res, n_res;
    t_out_word       r_out, n_out;

    logic            link_we;
    logic [AW-1:0]   link_waddr, link_raddr;
    logic [CW-1:0]   link_wdata, link_rdata;
    logic            st_we;
    logic [AW-1:0]   st_waddr, st_raddr;
    logic [1:0]      st_wdata, st_rdata;
    logic            rq_we;
    logic [AW-1:0]   rq_waddr, rq_raddr;
    logic [AW-1:0]   rq_wdata, rq_rdata;

    sap_ram #(.WIDTH(CW), .DEPTH(SLOTS)) u_link (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    sap_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_state (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    sap_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_queue (
        .i_clk   (i_clk),
        .i_we    (rq_we),
        .i_waddr (rq_waddr),
        .i_wdata (rq_wdata),
        .i_raddr (rq_raddr),
        .o_rdata (rq_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_qc        = r_qc;
        n_live      = r_live;
        n_next_id   = r_next_id;
        n_i         = r_i;
        n_acc       = r_acc;
        n_init      = r_init;
        n_idx       = r_idx;
        n_idx_ok    = r_idx_ok;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        link_we     = 1'b0;
        link_waddr  = r_i[AW-1:0];
        link_wdata  = r_i + 1'b1;
        link_raddr  = r_head[AW-1:0];
        st_we       = 1'b0;
        st_waddr    = r_i[AW-1:0];
        st_wdata    = SS_FREE;
        st_raddr    = r_i[AW-1:0];
        rq_we       = 1'b0;
        rq_waddr    = r_qc[AW-1:0];
        rq_wdata    = AW'(r_idx);
        rq_raddr    = r_i[AW-1:0];

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                st_raddr = AW'(i_in_word.slot_index);
                if (i_in_valid) begin
                    n_idx    = i_in_word.slot_index;
                    n_idx_ok = int'(i_in_word.slot_index) < SLOTS;
                    n_i      = '0;
                    n_acc    = '0;
                    n_res    = '0;
                    unique case (i_in_word.cmd)
                        CMD_ALLOC: begin
                            if (r_head == NONE) begin
                                n_res.status = STAT_NOFREE;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_ALLOC;
                            end
                        end
                        CMD_RELEASE: n_state = S_REL;
                        CMD_COMMIT:  n_state = S_CMT_RD;
                        default:     n_state = S_RB_RD;
                    endcase
                end
            end
            S_ALLOC: begin
                st_we                 = 1'b1;
                st_waddr              = r_head[AW-1:0];
                st_wdata              = SS_ALLOC;
                n_head                = link_rdata;
                n_live                = r_live + 1'b1;
                n_res.status          = STAT_OK;
                n_res.granted_slot    = 6'(r_head);
                n_res.object_id       = r_next_id;
                n_next_id             = (r_next_id == {ID_W{1'b1}}) ? ID_W'(1)
                                                                    : r_next_id + 1'b1;
                n_state               = S_DONE;
            end
            S_REL: begin
                if (!r_idx_ok || st_rdata != SS_ALLOC || r_qc >= NONE) begin
                    n_res.status = STAT_REJECT;
                end else begin
                    rq_we        = 1'b1;
                    st_we        = 1'b1;
                    st_waddr     = AW'(r_idx);
                    st_wdata     = SS_PEND;
                    n_qc         = r_qc + 1'b1;
                    n_res.status = STAT_OK;
                end
                n_state = S_DONE;
            end
            S_CMT_RD: begin
                if (r_i == r_qc) begin
                    n_res.status         = STAT_OK;
                    n_res.released_count = 7'(r_qc);
                    n_live               = (r_live >= r_qc) ? r_live - r_qc : '0;
                    n_qc                 = '0;
                    n_state              = S_DONE;
                end else begin
                    n_state = S_CMT_WR;
                end
            end
            S_CMT_WR: begin
                link_we    = 1'b1;
                link_waddr = rq_rdata;
                link_wdata = r_head;
                st_we      = 1'b1;
                st_waddr   = rq_rdata;
                st_wdata   = SS_FREE;
                n_head     = CW'(rq_rdata);
                n_i        = r_i + 1'b1;
                n_state    = S_CMT_RD;
            end
            S_RB_RD: begin
                if (r_i == NONE) begin
                    n_head = r_idx_ok ? CW'(r_idx) : NONE;
                    n_qc   = '0;
                    n_live = r_acc;
                    if (r_init) begin
                        n_init  = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_res.status = STAT_OK;
                        n_state      = S_DONE;
                    end
                end else if (int'(r_i) < int'(r_idx)) begin
                    n_state = S_RB_WR;
                end else begin
                    link_we = 1'b1;
                    st_we   = 1'b1;
                    n_i     = r_i + 1'b1;
                end
            end
            S_RB_WR: begin
                st_we    = (st_rdata == SS_PEND);
                st_wdata = SS_ALLOC;
                if (st_rdata != SS_FREE) begin
                    n_acc = r_acc + 1'b1;
                end
                n_i     = r_i + 1'b1;
                n_state = S_RB_RD;
            end
            default: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out              = r_res;
                    n_out.active_count = 7'(r_live);
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RB_RD;
            r_head      <= '0;
            r_qc        <= '0;
            r_live      <= '0;
            r_next_id   <= '0;
            r_i         <= '0;
            r_acc       <= '0;
            r_init      <= 1'b1;
            r_idx       <= '0;
            r_idx_ok    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_qc        <= n_qc;
            r_live      <= n_live;
            r_next_id   <= n_next_id;
            r_i         <= n_i;
            r_acc       <= n_acc;
            r_init      <= n_init;
            r_idx       <= n_idx;
            r_idx_ok    <= n_idx_ok;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

// ===== design/sap_ram.sv =====
// ----------------------------------------------------------------------------
// Slot allocator RAM
// Simple dual port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module sap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = sap_pkg::SLOTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/sap_checker.sv =====
// ----------------------------------------------------------------------------
// Slot allocator checker
// Port level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module sap_checker #(
    parameter int SLOTS = sap_pkg::SLOTS_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input sap_pkg::t_out_word o_out_word
);
    import sap_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("Stalled result word changed or dropped.");

    a_reset_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("Input not stalled during the free list build after reset.");

    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("Input taken again before the word in work finished.");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status != STAT_OK |->
            o_out_word.granted_slot == '0 && o_out_word.object_id == '0
            && o_out_word.released_count == '0)
        else $error("Failed word carries a slot, id or count.");

    a_active_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> int'(o_out_word.active_count) <= SLOTS)
        else $error("Active count exceeds the pool size.");

endmodule

bind slot_allocator_deferred_release sap_checker #(.SLOTS(SLOTS)) u_sap_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
